// ===== rtl/core/pid_regulator_clamped_unit_assert.svh =====
// Assertion macros for the PID regulator checker.
// Each macro takes a label, an antecedent and a consequent.
`ifndef PID_REGULATOR_CLAMPED_UNIT_ASSERT_SVH
`define PID_REGULATOR_CLAMPED_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIDRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidrc: check failed");

// Consequent must hold in the cycle after the antecedent.
`define PIDRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidrc: check failed");

`endif

// ===== rtl/core/pidrc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidrc_pkg
// Widths, register codes, reset values and payload types shared by the
// PID regulator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pidrc_pkg;

    localparam int SampleW  = 16;
    localparam int ErrW     = SampleW + 1;
    localparam int DeltaW   = ErrW + 1;
    localparam int GainW    = 32;
    localparam int LimitW   = 16;
    localparam int FracW    = 16;
    localparam int IntW     = LimitW + FracW;     // clamped integrator, Q16.16
    localparam int ProdPW   = GainW + ErrW;       // kp * err, ki_ts * err
    localparam int ProdDW   = GainW + DeltaW;     // kd_over_ts * delta
    localparam int IsumW    = ProdPW + 1;         // integrator + ki_ts * err
    localparam int PdW      = ProdDW + 1;         // p term + d term
    localparam int SumW     = PdW + 1;            // all three terms
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic signed [LimitW-1:0] LimitHighReset = 16'sh7FFF;
    localparam logic signed [LimitW-1:0] LimitLowReset  = 16'sh8000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KP         = 3'd0,
        REG_KI_TS      = 3'd1,
        REG_KD_OVER_TS = 3'd2,
        REG_LIMIT_HIGH = 3'd3,
        REG_LIMIT_LOW  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GainW-1:0]  kp;
        logic signed [GainW-1:0]  ki_ts;
        logic signed [GainW-1:0]  kd_over_ts;
        logic signed [LimitW-1:0] upper_lim;
        logic signed [LimitW-1:0] lower_lim;
    } cfg_t;

    typedef struct packed {
        logic                     restart;
        logic signed [ErrW-1:0]   err;
        logic signed [DeltaW-1:0] delta;
    } err_item_t;

    typedef struct packed {
        logic                     restart;
        logic signed [ProdPW-1:0] p_term;
        logic signed [ProdPW-1:0] i_incr;
        logic signed [ProdDW-1:0] d_term;
    } prod_item_t;

    typedef struct packed {
        logic                   restart;
        logic signed [PdW-1:0]  pd_sum;
        logic signed [IntW-1:0] integ;
    } acc_item_t;

    // Limit as a Q16.16 value.
    function automatic logic signed [IntW-1:0] limit_q(input logic signed [LimitW-1:0] lim);
        return {lim, {FracW{1'b0}}};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pidrc_if.sv =====
// ----------------------------------------------------------------------------
// pidrc_if
// Valid/ready channels of the PID regulator: sample in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidrc_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pidrc_pkg::SampleW-1:0]     reference;
    logic signed [pidrc_pkg::SampleW-1:0]     feedback;
    logic                                     restart;

    modport source (output valid, output reference, output feedback, output restart,
                    input ready);
    modport sink   (input valid, input reference, input feedback, input restart,
                    output ready);
endinterface

interface pidrc_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pidrc_pkg::LimitW-1:0]      drive;
    logic                                     saturated;

    modport source (output valid, output drive, output saturated, input ready);
    modport sink   (input valid, input drive, input saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pidrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pidrc_cfg_regs
// Gain and limit registers, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pidrc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pidrc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [pidrc_pkg::CfgDataW-1:0]    cfg_wdata,
    output pidrc_pkg::cfg_t                   cfg
);

    pidrc_pkg::cfg_t cfg_reg;
    pidrc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pidrc_pkg::REG_KP:         cfg_next.kp         = cfg_wdata;
                pidrc_pkg::REG_KI_TS:      cfg_next.ki_ts      = cfg_wdata;
                pidrc_pkg::REG_KD_OVER_TS: cfg_next.kd_over_ts = cfg_wdata;
                pidrc_pkg::REG_LIMIT_HIGH:
                    cfg_next.upper_lim = cfg_wdata[pidrc_pkg::LimitW-1:0];
                pidrc_pkg::REG_LIMIT_LOW:
                    cfg_next.lower_lim = cfg_wdata[pidrc_pkg::LimitW-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp         <= '0;
            cfg_reg.ki_ts      <= '0;
            cfg_reg.kd_over_ts <= '0;
            cfg_reg.upper_lim  <= pidrc_pkg::LimitHighReset;
            cfg_reg.lower_lim  <= pidrc_pkg::LimitLowReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pidrc_err_stage.sv =====
// ----------------------------------------------------------------------------
// pidrc_err_stage
// Input register: forms the error and its change against the last error.
// ----------------------------------------------------------------------------
`default_nettype none

module pidrc_err_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  logic signed [pidrc_pkg::SampleW-1:0]  reference,
    input  logic signed [pidrc_pkg::SampleW-1:0]  feedback,
    input  logic                                  restart,
    output logic                                  dn_valid,
    input  logic                                  dn_ready,
    output pidrc_pkg::err_item_t                  dn_item
);

    logic                                 valid_reg;
    logic                                 valid_next;
    pidrc_pkg::err_item_t                 item_reg;
    pidrc_pkg::err_item_t                 item_next;
    logic signed [pidrc_pkg::ErrW-1:0]    prev_err_reg;
    logic                                 load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        item_next.restart = restart;
        item_next.err     = {reference[pidrc_pkg::SampleW-1], reference}
                          - {feedback[pidrc_pkg::SampleW-1], feedback};
        item_next.delta   = {item_next.err[pidrc_pkg::ErrW-1], item_next.err}
                          - {prev_err_reg[pidrc_pkg::ErrW-1], prev_err_reg};
        valid_next        = load || (valid_reg && !dn_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            prev_err_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            // a restart leaves the last error alone
            if (load && !restart)
            begin
                prev_err_reg <= item_next.err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pidrc_mul_stage.sv =====
// ----------------------------------------------------------------------------
// pidrc_mul_stage
// Product stage: the three gain multiplies, each registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pidrc_mul_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pidrc_pkg::cfg_t        cfg,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  pidrc_pkg::err_item_t   up_item,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output pidrc_pkg::prod_item_t  dn_item
);

    localparam int PExt = pidrc_pkg::ProdPW - pidrc_pkg::GainW;
    localparam int EExt = pidrc_pkg::ProdPW - pidrc_pkg::ErrW;
    localparam int DExt = pidrc_pkg::ProdDW - pidrc_pkg::GainW;
    localparam int QExt = pidrc_pkg::ProdDW - pidrc_pkg::DeltaW;

    logic                                   valid_reg;
    logic                                   valid_next;
    pidrc_pkg::prod_item_t                  item_reg;
    pidrc_pkg::prod_item_t                  item_next;
    logic signed [pidrc_pkg::ProdPW-1:0]    kp_x;
    logic signed [pidrc_pkg::ProdPW-1:0]    ki_x;
    logic signed [pidrc_pkg::ProdPW-1:0]    err_x;
    logic signed [pidrc_pkg::ProdDW-1:0]    kd_x;
    logic signed [pidrc_pkg::ProdDW-1:0]    delta_x;
    logic                                   load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        kp_x    = {{PExt{cfg.kp[pidrc_pkg::GainW-1]}}, cfg.kp};
        ki_x    = {{PExt{cfg.ki_ts[pidrc_pkg::GainW-1]}}, cfg.ki_ts};
        err_x   = {{EExt{up_item.err[pidrc_pkg::ErrW-1]}}, up_item.err};
        kd_x    = {{DExt{cfg.kd_over_ts[pidrc_pkg::GainW-1]}}, cfg.kd_over_ts};
        delta_x = {{QExt{up_item.delta[pidrc_pkg::DeltaW-1]}}, up_item.delta};

        item_next.restart = up_item.restart;
        item_next.p_term  = kp_x * err_x;
        item_next.i_incr  = ki_x * err_x;
        item_next.d_term  = kd_x * delta_x;
        valid_next        = load || (valid_reg && !dn_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pidrc_acc_stage.sv =====
// ----------------------------------------------------------------------------
// pidrc_acc_stage
// Integrator update with clamp, and the sum of the proportional and
// derivative terms.
// ----------------------------------------------------------------------------
`default_nettype none

module pidrc_acc_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pidrc_pkg::cfg_t        cfg,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  pidrc_pkg::prod_item_t  up_item,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output pidrc_pkg::acc_item_t   dn_item
);

    localparam int IExt = pidrc_pkg::IsumW - pidrc_pkg::IntW;
    localparam int PExt = pidrc_pkg::PdW - pidrc_pkg::ProdPW;

    logic                                 valid_reg;
    logic                                 valid_next;
    pidrc_pkg::acc_item_t                 item_reg;
    pidrc_pkg::acc_item_t                 item_next;
    logic signed [pidrc_pkg::IntW-1:0]    integ_reg;
    logic signed [pidrc_pkg::IntW-1:0]    hi_q;
    logic signed [pidrc_pkg::IntW-1:0]    lo_q;
    logic signed [pidrc_pkg::IsumW-1:0]   isum;
    logic signed [pidrc_pkg::IsumW-1:0]   hi_x;
    logic signed [pidrc_pkg::IsumW-1:0]   lo_x;
    logic                                 load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        hi_q = pidrc_pkg::limit_q(cfg.upper_lim);
        lo_q = pidrc_pkg::limit_q(cfg.lower_lim);
        hi_x = {{IExt{hi_q[pidrc_pkg::IntW-1]}}, hi_q};
        lo_x = {{IExt{lo_q[pidrc_pkg::IntW-1]}}, lo_q};
        isum = {{IExt{integ_reg[pidrc_pkg::IntW-1]}}, integ_reg}
             + {up_item.i_incr[pidrc_pkg::ProdPW-1], up_item.i_incr};

        item_next.restart = up_item.restart;
        item_next.pd_sum  = {{PExt{up_item.p_term[pidrc_pkg::ProdPW-1]}}, up_item.p_term}
                          + {up_item.d_term[pidrc_pkg::ProdDW-1], up_item.d_term};
        // upper limit is tested first, so with inverted limits a sum above the upper limit resolves high
        if (up_item.restart)
        begin
            item_next.integ = '0;
        end
        else if (isum > hi_x)
        begin
            item_next.integ = hi_q;
        end
        else if (isum < lo_x)
        begin
            item_next.integ = lo_q;
        end
        else
        begin
            item_next.integ = isum[pidrc_pkg::IntW-1:0];
        end
        valid_next = load || (valid_reg && !dn_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            integ_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                integ_reg <= item_next.integ;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pidrc_out_stage.sv =====
// ----------------------------------------------------------------------------
// pidrc_out_stage
// Output register: total sum, clamp to the limits, saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pidrc_out_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pidrc_pkg::cfg_t                       cfg,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  pidrc_pkg::acc_item_t                  up_item,
    output logic                                  dn_valid,
    input  logic                                  dn_ready,
    output logic signed [pidrc_pkg::LimitW-1:0]   drive,
    output logic                                  saturated
);

    localparam int IExt = pidrc_pkg::SumW - pidrc_pkg::IntW;

    logic                                   valid_reg;
    logic                                   valid_next;
    logic signed [pidrc_pkg::LimitW-1:0]    drive_reg;
    logic signed [pidrc_pkg::LimitW-1:0]    drive_next;
    logic                                   sat_reg;
    logic                                   sat_next;
    logic signed [pidrc_pkg::IntW-1:0]      hi_q;
    logic signed [pidrc_pkg::IntW-1:0]      lo_q;
    logic signed [pidrc_pkg::SumW-1:0]      sum;
    logic signed [pidrc_pkg::SumW-1:0]      hi_x;
    logic signed [pidrc_pkg::SumW-1:0]      lo_x;
    logic signed [pidrc_pkg::IntW-1:0]      clamped;
    logic                                   load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        hi_q = pidrc_pkg::limit_q(cfg.upper_lim);
        lo_q = pidrc_pkg::limit_q(cfg.lower_lim);
        hi_x = {{IExt{hi_q[pidrc_pkg::IntW-1]}}, hi_q};
        lo_x = {{IExt{lo_q[pidrc_pkg::IntW-1]}}, lo_q};
        sum  = {up_item.pd_sum[pidrc_pkg::PdW-1], up_item.pd_sum}
             + {{IExt{up_item.integ[pidrc_pkg::IntW-1]}}, up_item.integ};

        if (sum > hi_x)
        begin
            clamped  = hi_q;
            sat_next = 1'b1;
        end
        else if (sum < lo_x)
        begin
            clamped  = lo_q;
            sat_next = 1'b1;
        end
        else
        begin
            clamped  = sum[pidrc_pkg::IntW-1:0];
            sat_next = 1'b0;
        end

        // integer part; the clamped value always fits Q16.16
        drive_next = clamped[pidrc_pkg::IntW-1:pidrc_pkg::FracW];
        if (up_item.restart)
        begin
            drive_next = '0;
            sat_next   = 1'b0;
        end
        valid_next = load || (valid_reg && !dn_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    assign dn_valid  = valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pid_regulator_clamped_unit.sv =====
// ----------------------------------------------------------------------------
// pid_regulator_clamped_unit
// PID controller with a clamped integrator and clamped output.
//
// Usage:
//   sample carries reference, feedback and restart; result carries drive
//   and saturated. Both use valid/ready; a transfer happens on a rising
//   edge with valid and ready high.
//   Gains and limits are written through cfg_we / cfg_index / cfg_wdata
//   while no sample is in flight.
//   Four register stages (error, products, integrator, output): a result
//   is valid once its sample has passed through all four, and one sample
//   is taken every cycle while result.ready is high. The integrator update
//   is a single registered loop in the third stage, which sets that rate.
//   When result.ready is low, results hold and empty stages still fill, so
//   up to four samples are taken before sample.ready drops.
//   A restart sample clears the integrator and returns drive 0, not
//   saturated; the stored last error is kept.
//   Reset clears the pipeline, the integrator and the last error, zeroes
//   the gains and opens the limits to the full 16-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_regulator_clamped_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pidrc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [pidrc_pkg::CfgDataW-1:0]    cfg_wdata,
    pidrc_sample_if.sink                      sample,
    pidrc_result_if.source                    result
);

    pidrc_pkg::cfg_t        cfg;
    logic                   err_valid;
    logic                   err_ready;
    pidrc_pkg::err_item_t   err_item;
    logic                   prod_valid;
    logic                   prod_ready;
    pidrc_pkg::prod_item_t  prod_item;
    logic                   acc_valid;
    logic                   acc_ready;
    pidrc_pkg::acc_item_t   acc_item;

    pidrc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidrc_err_stage u_err_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (sample.valid),
        .up_ready  (sample.ready),
        .reference (sample.reference),
        .feedback  (sample.feedback),
        .restart   (sample.restart),
        .dn_valid  (err_valid),
        .dn_ready  (err_ready),
        .dn_item   (err_item)
    );

    pidrc_mul_stage u_mul_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (err_valid),
        .up_ready (err_ready),
        .up_item  (err_item),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .dn_item  (prod_item)
    );

    pidrc_acc_stage u_acc_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .up_item  (prod_item),
        .dn_valid (acc_valid),
        .dn_ready (acc_ready),
        .dn_item  (acc_item)
    );

    pidrc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .up_valid  (acc_valid),
        .up_ready  (acc_ready),
        .up_item   (acc_item),
        .dn_valid  (result.valid),
        .dn_ready  (result.ready),
        .drive     (result.drive),
        .saturated (result.saturated)
    );

endmodule

`default_nettype wire

// ===== rtl/core/pidrc_checker.sv =====
// ----------------------------------------------------------------------------
// pidrc_checker
// Port-level checks of the PID regulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_regulator_clamped_unit_assert.svh"

module pidrc_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pidrc_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [pidrc_pkg::CfgDataW-1:0]        cfg_wdata,
    input  logic                                  sample_valid,
    input  logic                                  sample_ready,
    input  logic                                  result_valid,
    input  logic                                  result_ready,
    input  logic signed [pidrc_pkg::LimitW-1:0]   drive,
    input  logic                                  saturated
);

    localparam logic [2:0] Depth = 3'd4;

    logic signed [pidrc_pkg::LimitW-1:0]  lim_hi_reg;
    logic signed [pidrc_pkg::LimitW-1:0]  lim_lo_reg;
    logic [2:0]                           count_reg;
    logic [2:0]                           count_next;
    logic                                 in_xfer;
    logic                                 out_xfer;

    assign in_xfer  = sample_valid && sample_ready;
    assign out_xfer = result_valid && result_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_xfer && !out_xfer)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    // mirror the limit registers from the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_hi_reg <= pidrc_pkg::LimitHighReset;
            lim_lo_reg <= pidrc_pkg::LimitLowReset;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we && (cfg_index == pidrc_pkg::REG_LIMIT_HIGH))
            begin
                lim_hi_reg <= cfg_wdata[pidrc_pkg::LimitW-1:0];
            end
            if (cfg_we && (cfg_index == pidrc_pkg::REG_LIMIT_LOW))
            begin
                lim_lo_reg <= cfg_wdata[pidrc_pkg::LimitW-1:0];
            end
        end
    end

    `PIDRC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(drive) && $stable(saturated))

    `PIDRC_ASSERT_NOW(a_no_invented_result, result_valid, count_reg != 3'd0)

    `PIDRC_ASSERT_NOW(a_full_blocks_input, count_reg == Depth && !result_ready,
        !sample_ready)

    `PIDRC_ASSERT_NOW(a_sat_at_limit, result_valid && saturated,
        drive == lim_hi_reg || drive == lim_lo_reg)

endmodule

bind pid_regulator_clamped_unit pidrc_checker u_pidrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .drive        (result.drive),
    .saturated    (result.saturated)
);

`default_nettype wire
